/* rtl/iar_pkg.sv */
// Package for the integer to ASCII radix unit.
// Holds the widths, character codes, operation codes and the digit cell control word.
// Depends on nothing; used by iar_digit_cell and integer_to_ascii_radix_unit.
package iar_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int NUM_CELLS   = 20;
	localparam int DIGIT_W     = 4;
	localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
	localparam int REM_W       = $clog2(NUM_CELLS + 1);

	localparam logic [1:0] OP_SIGNED_DEC   = 2'd0;
	localparam logic [1:0] OP_UNSIGNED_DEC = 2'd1;
	localparam logic [1:0] OP_HEX          = 2'd2;
	localparam logic [1:0] OP_HEX_ALT      = 2'd3;

	localparam logic [7:0] CHAR_MINUS   = 8'h2D;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_A_LOWER = 8'h61;

	typedef struct packed {
		logic clear;
		logic convert;
		logic move;
		logic hex;
	} cell_ctrl_t;

	function automatic logic [7:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		logic [7:0] ext;
		ext = {{(8 - DIGIT_W){1'b0}}, d};
		if (d < DIGIT_W'(10)) begin
			digit_to_char = CHAR_ZERO + ext;
		end else begin
			digit_to_char = CHAR_A_LOWER + ext - 8'd10;
		end
	endfunction

endpackage

/* rtl/iar_digit_cell.sv */
// One digit cell of the conversion row: holds a decimal or hexadecimal digit.
// Shifts in one bit per cycle while convert is set, with the add-three correction in decimal mode.
// Depends on iar_pkg for the digit width and the cell control word.
module iar_digit_cell (
	input  logic                        clk,
	input  iar_pkg::cell_ctrl_t         ctrl,
	input  logic                        carry_in,
	input  logic [iar_pkg::DIGIT_W-1:0] digit_in,
	output logic [iar_pkg::DIGIT_W-1:0] digit,
	output logic                        carry_out
);

	logic [iar_pkg::DIGIT_W-1:0] digit_q;
	logic [iar_pkg::DIGIT_W-1:0] adj;

	always_comb begin
		if (!ctrl.hex && digit_q >= iar_pkg::DIGIT_W'(5)) begin
			adj = digit_q + iar_pkg::DIGIT_W'(3);
		end else begin
			adj = digit_q;
		end
	end

	assign carry_out = adj[iar_pkg::DIGIT_W-1];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.convert) begin
			digit_q <= {adj[iar_pkg::DIGIT_W-2:0], carry_in};
		end else if (ctrl.move) begin
			digit_q <= digit_in;
		end
	end

endmodule

/* rtl/integer_to_ascii_radix_unit.sv */
// Integer to ASCII radix unit: signed decimal, unsigned decimal or lowercase hexadecimal.
// A word is taken when start is high and busy low; conversion runs one bit per cycle
// through a row of twenty digit cells, then leading zeros are skipped and one character
// per cycle leaves; busy stays high until the last character is sent, so no new word is taken meanwhile.
// A negative signed value is preceded by a minus sign; the receiver cannot stall.
// Reset (arst_n low, asynchronous) returns the unit to idle with no character pending.
module integer_to_ascii_radix_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      operation,
	input  logic [iar_pkg::VALUE_WIDTH-1:0] value,
	output logic                            strobe,
	output logic [7:0]                      character,
	output logic                            last
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_SIGN = 3'd2;
	localparam logic [2:0] ST_SKIP = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]                        state_q;
	logic [iar_pkg::VALUE_WIDTH-1:0]   bin_q;
	logic                              neg_q;
	logic                              hex_q;
	logic [iar_pkg::BIT_CNT_W-1:0]     bit_cnt_q;
	logic [iar_pkg::REM_W-1:0]         rem_q;
	logic                              strobe_q;
	logic [7:0]                        character_q;
	logic                              last_q;

	logic                              accept;
	logic                              negative;
	logic [iar_pkg::VALUE_WIDTH-1:0]   magnitude;
	logic [iar_pkg::DIGIT_W-1:0]       top_digit;
	logic                              skip_zero;
	iar_pkg::cell_ctrl_t               ctrl;

	logic [iar_pkg::DIGIT_W-1:0]       digit_w [iar_pkg::NUM_CELLS];
	logic                              carry_w [iar_pkg::NUM_CELLS];

	assign accept    = start && !busy;
	assign busy      = state_q != ST_IDLE;
	assign negative  = operation == iar_pkg::OP_SIGNED_DEC && value[iar_pkg::VALUE_WIDTH-1];
	assign magnitude = negative ? (~value) + {{(iar_pkg::VALUE_WIDTH-1){1'b0}}, 1'b1} : value;
	assign top_digit = digit_w[iar_pkg::NUM_CELLS-1];
	assign skip_zero = top_digit == '0 && rem_q != iar_pkg::REM_W'(1);

	always_comb begin
		ctrl.clear   = accept;
		ctrl.convert = state_q == ST_CONV;
		ctrl.move    = (state_q == ST_SKIP && skip_zero) || state_q == ST_EMIT;
		ctrl.hex     = hex_q;
	end

	for (genvar g = 0; g < iar_pkg::NUM_CELLS; g++) begin : g_row
		logic                        cin;
		logic [iar_pkg::DIGIT_W-1:0] din;
		if (g == 0) begin : g_first
			assign cin = bin_q[iar_pkg::VALUE_WIDTH-1];
			assign din = '0;
		end else begin : g_next
			assign cin = carry_w[g-1];
			assign din = digit_w[g-1];
		end
		iar_digit_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.carry_in  (cin),
			.digit_in  (din),
			.digit     (digit_w[g]),
			.carry_out (carry_w[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			rem_q     <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_CONV;
						bit_cnt_q <= '0;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + iar_pkg::BIT_CNT_W'(1);
					if (bit_cnt_q == iar_pkg::BIT_CNT_W'(iar_pkg::VALUE_WIDTH - 1)) begin
						state_q <= neg_q ? ST_SIGN : ST_SKIP;
						rem_q   <= iar_pkg::REM_W'(iar_pkg::NUM_CELLS);
					end
				end
				ST_SIGN: begin
					strobe_q <= 1'b1;
					state_q  <= ST_SKIP;
				end
				ST_SKIP: begin
					if (skip_zero) begin
						rem_q <= rem_q - iar_pkg::REM_W'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					rem_q    <= rem_q - iar_pkg::REM_W'(1);
					if (rem_q == iar_pkg::REM_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= magnitude;
			neg_q <= negative;
			hex_q <= operation == iar_pkg::OP_HEX || operation == iar_pkg::OP_HEX_ALT;
		end else if (state_q == ST_CONV) begin
			bin_q <= {bin_q[iar_pkg::VALUE_WIDTH-2:0], 1'b0};
		end
		if (state_q == ST_SIGN) begin
			character_q <= iar_pkg::CHAR_MINUS;
			last_q      <= 1'b0;
		end else begin
			character_q <= iar_pkg::digit_to_char(top_digit);
			last_q      <= rem_q == iar_pkg::REM_W'(1);
		end
	end

	assign strobe    = strobe_q;
	assign character = character_q;
	assign last      = last_q;

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("Unit not busy after taking a word.");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && last_q |-> state_q == ST_IDLE)
		else $error("Final character shown while the unit is still working.");

	a_dec_digit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && !hex_q |-> top_digit < iar_pkg::DIGIT_W'(10))
		else $error("Decimal digit out of range.");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SKIP || state_q == ST_EMIT |->
			rem_q <= iar_pkg::REM_W'(iar_pkg::NUM_CELLS) && rem_q != '0)
		else $error("Digit count out of range.");
`endif

endmodule
